// ===== src/lcdws_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdws_pkg
// Types, constants and the control-store program shared by the character
// LCD write sequencer.
// ----------------------------------------------------------------------------
package lcdws_pkg;

  // Delays in 100 ns units
  localparam logic [19:0] PowerUpWait = 20'd1000000;
  localparam logic [15:0] WaitData    = 16'd500;
  localparam logic [15:0] WaitLong    = 16'd20000;
  localparam logic [15:0] WaitShort   = 16'd400;
  localparam logic [15:0] WaitWake1   = 16'd50000;
  localparam logic [15:0] WaitWake2   = 16'd1000;

  // Fixed instruction bytes
  localparam logic [7:0] CmdWake       = 8'h30;
  localparam logic [7:0] CmdDisplayOff = 8'h08;
  localparam logic [7:0] CmdClear      = 8'h01;
  localparam logic [7:0] CmdEntryMode  = 8'h06;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgBus8bit     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTwoLines    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgLargeFont   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgInitByInstr = 2'd3;

  // Program counter
  localparam int unsigned PcW = 3;
  localparam logic [PcW-1:0] PcWrite     = 3'd0;
  localparam logic [PcW-1:0] PcInitWake  = 3'd1;
  localparam logic [PcW-1:0] PcInitFset  = 3'd4;

  typedef struct packed {
    logic       mode;
    logic       is_data;
    logic [7:0] value;
  } in_t;

  typedef struct packed {
    logic        reg_select;
    logic [7:0]  bus_value;
    logic [19:0] delay_before;
    logic [15:0] delay_after;
    logic        last;
  } out_t;

  typedef enum logic [2:0] {
    ByteInput,
    ByteWake,
    ByteFset,
    ByteDispOff,
    ByteClear,
    ByteEntry
  } byte_sel_e;

  typedef enum logic [2:0] {
    AfterByType,
    AfterLong,
    AfterShort,
    AfterWake1,
    AfterWake2
  } after_sel_e;

  // One control word per step
  typedef struct packed {
    byte_sel_e  byte_sel;
    logic       rs_from_input;
    logic       power_up;   // power-up wait if first strobe of request
    after_sel_e after_sel;
    logic       split;      // two nibbles on a 4-bit bus
    logic       last;
  } uword_t;

  function automatic uword_t ucode(input logic [PcW-1:0] pc);
    uword_t w;
    case (pc)
      3'd0:    w = '{ByteInput,   1'b1, 1'b0, AfterByType, 1'b1, 1'b1};
      3'd1:    w = '{ByteWake,    1'b0, 1'b1, AfterWake1,  1'b0, 1'b0};
      3'd2:    w = '{ByteWake,    1'b0, 1'b0, AfterWake2,  1'b0, 1'b0};
      3'd3:    w = '{ByteWake,    1'b0, 1'b0, AfterShort,  1'b0, 1'b0};
      3'd4:    w = '{ByteFset,    1'b0, 1'b1, AfterShort,  1'b1, 1'b0};
      3'd5:    w = '{ByteDispOff, 1'b0, 1'b0, AfterShort,  1'b1, 1'b0};
      3'd6:    w = '{ByteClear,   1'b0, 1'b0, AfterLong,   1'b1, 1'b0};
      default: w = '{ByteEntry,   1'b0, 1'b0, AfterShort,  1'b1, 1'b1};
    endcase
    return w;
  endfunction

endpackage

// ===== src/char_lcd_write_sequencer.sv =====
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer
// Turns write and init requests into LCD enable-strobe descriptors, stepping
// through a small control-store program, one strobe per unstalled cycle.
// ----------------------------------------------------------------------------
//  channel | signals                          | transfer when
//  --------+----------------------------------+---------------------------
//  in      | in_valid_i, in_stall_o, in_data_i   | valid & !stall
//  out     | out_valid_o, out_stall_i, out_data_o| valid & !stall
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | valid & ready
//
// A request producing N strobes (1 to 11) occupies the sequencer: it is loaded,
// then stepped one program step or nibble per cycle unless the output stalls.
// The next request is taken as soon as the last strobe sits in the output
// register. A stalled output register holds the sequencer in place.
// Reset clears the control state and loads the register defaults.
module char_lcd_write_sequencer
  import lcdws_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_t               out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic               cfg_data_i
);

  logic           bus_8bit_q, two_lines_q, large_font_q, init_instr_q;
  logic           busy_q, busy_d;
  logic [PcW-1:0] pc_q, pc_d;
  logic           nib_q, nib_d;
  logic           first_q, first_d;
  logic           out_valid_q, out_valid_d;
  logic           rs_q;
  logic [7:0]     val_q;
  out_t           out_q, strobe;

  logic           in_xfer, step;
  uword_t         uw;
  logic [7:0]     byte_v;
  logic [15:0]    after_v;
  logic           split_v;

  assign in_stall_o  = busy_q;
  assign in_xfer     = in_valid_i && !busy_q;
  assign step        = busy_q && (!out_valid_q || !out_stall_i);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign uw      = ucode(pc_q);
  assign split_v = uw.split && !bus_8bit_q;

  always_comb begin
    case (uw.byte_sel)
      ByteInput:   byte_v = val_q;
      ByteWake:    byte_v = CmdWake;
      ByteFset:    byte_v = {3'b001, bus_8bit_q, two_lines_q, large_font_q, 2'b00};
      ByteDispOff: byte_v = CmdDisplayOff;
      ByteClear:   byte_v = CmdClear;
      ByteEntry:   byte_v = CmdEntryMode;
      default:     byte_v = CmdEntryMode;
    endcase
  end

  always_comb begin
    case (uw.after_sel)
      AfterByType: begin
        if (rs_q) begin
          after_v = WaitData;
        end else if (val_q inside {[8'd1:8'd3]}) begin
          after_v = WaitLong;
        end else begin
          after_v = WaitShort;
        end
      end
      AfterLong:  after_v = WaitLong;
      AfterShort: after_v = WaitShort;
      AfterWake1: after_v = WaitWake1;
      AfterWake2: after_v = WaitWake2;
      default:    after_v = WaitShort;
    endcase
  end

  // Strobe descriptor and sequencing for the current step
  always_comb begin
    strobe.reg_select   = uw.rs_from_input && rs_q;
    strobe.delay_before = (uw.power_up && first_q) ? PowerUpWait : 20'd0;
    busy_d  = busy_q;
    pc_d    = pc_q;
    nib_d   = nib_q;
    first_d = first_q;
    if (split_v && !nib_q) begin
      strobe.bus_value   = {byte_v[7:4], 4'h0};
      strobe.delay_after = 16'd0;
      strobe.last        = 1'b0;
    end else begin
      strobe.bus_value   = split_v ? {byte_v[3:0], 4'h0} : byte_v;
      strobe.delay_after = after_v;
      strobe.last        = uw.last;
    end
    out_valid_d = out_valid_q && out_stall_i;
    if (step) begin
      out_valid_d = 1'b1;
      first_d     = 1'b0;
      if (split_v && !nib_q) begin
        nib_d = 1'b1;
      end else begin
        nib_d = 1'b0;
        pc_d  = pc_q + 1'b1;
        if (uw.last) begin
          busy_d = 1'b0;
        end
      end
    end
    if (in_xfer) begin
      busy_d  = 1'b1;
      nib_d   = 1'b0;
      first_d = 1'b1;
      if (!in_data_i.mode) begin
        pc_d = PcWrite;
      end else begin
        pc_d = init_instr_q ? PcInitWake : PcInitFset;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      pc_q         <= PcWrite;
      nib_q        <= 1'b0;
      first_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      bus_8bit_q   <= 1'b1;
      two_lines_q  <= 1'b0;
      large_font_q <= 1'b0;
      init_instr_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      nib_q       <= nib_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgBus8bit:     bus_8bit_q   <= cfg_data_i;
          CfgTwoLines:    two_lines_q  <= cfg_data_i;
          CfgLargeFont:   large_font_q <= cfg_data_i;
          CfgInitByInstr: init_instr_q <= cfg_data_i;
          default:        ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rs_q  <= in_data_i.is_data;
      val_q <= in_data_i.value;
    end
    if (step) begin
      out_q <= strobe;
    end
  end

endmodule
